// ===== rtl/gbm_pkg.sv =====
package gbm_pkg;

    localparam int UNIFORM_BITS = 32;
    localparam int FRAC_BITS    = 16;

    localparam int LOG_STEPS    = 32;
    localparam int SQRT_STEPS   = 28;
    localparam int HORNER_STEPS = 11;
    localparam int SIN_TERMS    = 5;
    localparam int CNT_W        = 5;
    localparam int IDX_W        = 4;

    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int V_W       = 56;
    localparam int DEV_W     = 24;
    localparam int DEV_SHIFT = 54 - FRAC_BITS;

    localparam logic [32:0] TWO_LN2_Q32 = 33'd5954088944;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [31:0] UNI_MASK    = 32'((64'd1 << UNIFORM_BITS) - 64'd1);
    localparam int          UNI_SHIFT   = 32 - UNIFORM_BITS;

    // sine terms first, then cosine terms
    localparam logic [7:0] HORNER_K [HORNER_STEPS] = '{
        8'd110, 8'd72, 8'd42, 8'd20, 8'd6,
        8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
    };
    localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] = '{
        32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882,
        32'd32537631, 32'd47721858, 32'd76695844, 32'd143165576, 32'd357913941,
        32'd2147483648
    };

    localparam logic REG_MEAN   = 1'b0;
    localparam logic REG_SPREAD = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_NORM, OP_LOG, OP_LN, OP_SQRT, OP_ANG, OP_T2,
        OP_HY, OP_HQ, OP_HFIX, OP_SIN, OP_DSIN, OP_DCOS, OP_SCALE, OP_OUT
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_LOG, S_LN, S_SQRT, S_ANG, S_T2, S_HY, S_HQ, S_HFIX,
        S_SIN, S_DSIN, S_DCOS, S_SCALE, S_OUT
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic             from_stored;
    } t_cmd;

    typedef struct packed {
        logic norm_done;
    } t_sts;

endpackage

// ===== rtl/gbm_if.sv =====
interface gbm_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] uniform_radius;
    logic [31:0] uniform_angle;

    modport source (output valid, output uniform_radius, output uniform_angle, input ready);
    modport sink (input valid, input uniform_radius, input uniform_angle, output ready);
endinterface

interface gbm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample;
    logic        from_stored;

    modport source (output valid, output sample, output from_stored, input ready);
    modport sink (input valid, input sample, input from_stored, output ready);
endinterface

// ===== rtl/gbm_ctrl.sv =====
module gbm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output gbm_pkg::t_cmd o_cmd,
    input  gbm_pkg::t_sts i_sts
);
    import gbm_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_have, n_have;
    logic             r_fromst, n_fromst;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_have      <= 1'b0;
            r_fromst    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_have      <= n_have;
            r_fromst    <= n_fromst;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_have      = r_have;
        n_fromst    = r_fromst;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (r_have) begin
                        n_have   = 1'b0;
                        n_fromst = 1'b1;
                        n_state  = S_SCALE;
                    end else begin
                        n_fromst = 1'b0;
                        n_state  = S_NORM;
                    end
                end
            end
            S_NORM: begin
                if (i_sts.norm_done) begin
                    n_cnt   = '0;
                    n_state = S_LOG;
                end
            end
            S_LOG: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(LOG_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_LN;
                end
            end
            S_LN: begin
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_ANG;
                end
            end
            S_ANG: n_state = S_T2;
            S_T2: begin
                n_cnt   = '0;
                n_state = S_HY;
            end
            S_HY: n_state = S_HQ;
            S_HQ: n_state = S_HFIX;
            S_HFIX: begin
                if (r_cnt == CNT_W'(HORNER_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_SIN;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_HY;
                end
            end
            S_SIN: n_state = S_DSIN;
            S_DSIN: n_state = S_DCOS;
            S_DCOS: begin
                n_have  = 1'b1;
                n_state = S_SCALE;
            end
            S_SCALE: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = (r_state == S_IDLE);
        o_out_valid       = r_out_valid;
        o_cmd.idx         = r_cnt[IDX_W-1:0];
        o_cmd.from_stored = r_fromst;
        case (r_state)
            S_IDLE:  o_cmd.op = (i_in_valid && !r_have) ? OP_LOAD : OP_NONE;
            S_NORM:  o_cmd.op = OP_NORM;
            S_LOG:   o_cmd.op = OP_LOG;
            S_LN:    o_cmd.op = OP_LN;
            S_SQRT:  o_cmd.op = OP_SQRT;
            S_ANG:   o_cmd.op = OP_ANG;
            S_T2:    o_cmd.op = OP_T2;
            S_HY:    o_cmd.op = OP_HY;
            S_HQ:    o_cmd.op = OP_HQ;
            S_HFIX:  o_cmd.op = OP_HFIX;
            S_SIN:   o_cmd.op = OP_SIN;
            S_DSIN:  o_cmd.op = OP_DSIN;
            S_DCOS:  o_cmd.op = OP_DCOS;
            S_SCALE: o_cmd.op = OP_SCALE;
            S_OUT:   o_cmd.op = out_free ? OP_OUT : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/gbm_dp.sv =====
module gbm_dp (
    input  logic          i_clk,
    input  gbm_pkg::t_cmd i_cmd,
    output gbm_pkg::t_sts o_sts,
    input  logic [31:0]   i_uniform_radius,
    input  logic [31:0]   i_uniform_angle,
    input  logic [31:0]   i_mean,
    input  logic [31:0]   i_spread,
    output logic [31:0]   o_sample,
    output logic          o_from_stored
);
    import gbm_pkg::*;

    localparam logic [PROD_W-1:0] DEV_HALF    = PROD_W'(1) << (DEV_SHIFT - 1);
    localparam logic [PROD_W-1:0] DEV_POS_MAX = PROD_W'((64'd1 << (DEV_W - 1)) - 64'd1);
    localparam logic [PROD_W-1:0] DEV_NEG_MAX = PROD_W'(64'd1 << (DEV_W - 1));
    localparam logic [PROD_W-1:0] OUT_HALF    = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [V_W-1:0]    SQRT_TOP    = V_W'(1) << (2 * (SQRT_STEPS - 1));

    function automatic logic [DEV_W-1:0] make_dev(input logic [PROD_W-1:0] p,
                                                  input logic neg);
        logic [PROD_W-1:0] mag;
        logic [DEV_W-1:0]  res;
        mag = (p + DEV_HALF) >> DEV_SHIFT;
        if (neg) begin
            res = (mag > DEV_NEG_MAX) ? DEV_W'(DEV_NEG_MAX) : DEV_W'(PROD_W'(0) - mag);
        end else begin
            res = (mag > DEV_POS_MAX) ? DEV_W'(DEV_POS_MAX) : DEV_W'(mag);
        end
        return res;
    endfunction

    logic [31:0]       r_m, r_frac, r_ph;
    logic [5:0]        r_lz;
    logic [V_W-1:0]    r_v, r_root, r_bit;
    logic [30:0]       r_t, r_t2, r_a, r_b, r_y, r_q, r_s;
    logic              r_sw, r_neg, r_fs;
    logic [PROD_W-1:0] r_prod;
    logic [DEV_W-1:0]  r_dsin, r_stored;
    logic [31:0]       r_sample;

    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [31:0]       u1m;
    logic [5:0]        int_part;
    logic [37:0]       neg_log;
    logic [29:0]       ln_arg;
    logic [30:0]       ang_in;
    logic [32:0]       sq_m;
    logic [V_W-1:0]    trial;
    logic [37:0]       kq, rem;
    logic [30:0]       q_fix, h_val;
    logic [30:0]       sq, cq, s_val, c_val;
    logic              s_neg, c_neg;
    logic [DEV_W-1:0]  dev, dev_mag;
    logic [PROD_W-1:0] rnd;
    logic [41:0]       mag42, sv42, sum42;
    logic [31:0]       sat;

    assign u1m      = i_uniform_radius & UNI_MASK;
    assign int_part = 6'(UNIFORM_BITS - 31) + r_lz;
    assign neg_log  = {int_part, 32'd0} - {6'd0, r_frac};
    assign ln_arg   = neg_log[37:8];
    assign ang_in   = r_ph[29] ? (Q30_ONE - {1'b0, r_ph[29:0]}) : {1'b0, r_ph[29:0]};
    assign sq_m     = mul_p[63:31];
    assign trial    = r_root + r_bit;

    assign kq    = 38'(r_q) * 38'(HORNER_K[i_cmd.idx]);
    assign rem   = 38'(r_y) - kq;
    assign q_fix = r_q + 31'(rem >= 38'(HORNER_K[i_cmd.idx]));
    assign h_val = Q30_ONE - q_fix;

    assign sq    = r_sw ? r_b : r_s;
    assign cq    = r_sw ? r_s : r_b;
    assign s_val = r_ph[30] ? cq : sq;
    assign c_val = r_ph[30] ? sq : cq;
    assign s_neg = r_ph[31];
    assign c_neg = r_ph[31] ^ r_ph[30];

    assign dev     = i_cmd.from_stored ? r_stored : r_dsin;
    assign dev_mag = dev[DEV_W-1] ? DEV_W'(-dev) : dev;

    assign rnd   = (r_prod + OUT_HALF) >> FRAC_BITS;
    assign mag42 = rnd[41:0];
    assign sv42  = r_neg ? (42'd0 - mag42) : mag42;
    assign sum42 = sv42 + {{10{i_mean[31]}}, i_mean};
    assign sat   = (sum42[41:31] == {11{sum42[41]}}) ? sum42[31:0]
                 : (sum42[41] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_LOG: begin
                mul_a = MUL_W'(r_m);
                mul_b = MUL_W'(r_m);
            end
            OP_LN: begin
                mul_a = MUL_W'(ln_arg);
                mul_b = TWO_LN2_Q32;
            end
            OP_ANG: begin
                mul_a = MUL_W'(ang_in);
                mul_b = MUL_W'(HALF_PI_Q30);
            end
            OP_T2: begin
                mul_a = MUL_W'(r_t);
                mul_b = MUL_W'(r_t);
            end
            OP_HY: begin
                mul_a = MUL_W'(r_t2);
                mul_b = (i_cmd.idx >= IDX_W'(SIN_TERMS)) ? MUL_W'(r_b) : MUL_W'(r_a);
            end
            OP_HQ: begin
                mul_a = MUL_W'(r_y);
                mul_b = MUL_W'(HORNER_RECIP[i_cmd.idx]);
            end
            OP_SIN: begin
                mul_a = MUL_W'(r_t);
                mul_b = MUL_W'(r_a);
            end
            OP_DSIN: begin
                mul_a = r_root[MUL_W-1:0];
                mul_b = MUL_W'(s_val);
            end
            OP_DCOS: begin
                mul_a = r_root[MUL_W-1:0];
                mul_b = MUL_W'(c_val);
            end
            OP_SCALE: begin
                mul_a = MUL_W'(dev_mag);
                mul_b = MUL_W'(i_spread);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_m  <= (u1m == 32'd0) ? 32'd1 : u1m;
                r_lz <= '0;
                r_ph <= (i_uniform_angle & UNI_MASK) << UNI_SHIFT;
            end
            OP_NORM: begin
                if (r_m[31:24] == 8'd0) begin
                    r_m  <= r_m << 8;
                    r_lz <= r_lz + 6'd8;
                end else if (!r_m[31]) begin
                    r_m  <= r_m << 1;
                    r_lz <= r_lz + 6'd1;
                end
            end
            OP_LOG: begin
                r_frac <= {r_frac[30:0], sq_m[32]};
                r_m    <= sq_m[32] ? sq_m[32:1] : sq_m[31:0];
            end
            OP_LN: begin
                r_v    <= V_W'({mul_p[62:32], 24'd0});
                r_root <= '0;
                r_bit  <= SQRT_TOP;
            end
            OP_SQRT: begin
                if (r_v >= trial) begin
                    r_v    <= r_v - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_ANG: begin
                r_t  <= mul_p[60:30];
                r_sw <= r_ph[29];
            end
            OP_T2: begin
                r_t2 <= mul_p[60:30];
                r_a  <= Q30_ONE;
                r_b  <= Q30_ONE;
            end
            OP_HY: r_y <= mul_p[60:30];
            OP_HQ: r_q <= mul_p[62:32];
            OP_HFIX: begin
                if (i_cmd.idx >= IDX_W'(SIN_TERMS)) begin
                    r_b <= h_val;
                end else begin
                    r_a <= h_val;
                end
            end
            OP_SIN: r_s <= mul_p[60:30];
            OP_DSIN: r_dsin <= make_dev(mul_p, s_neg);
            OP_DCOS: r_stored <= make_dev(mul_p, c_neg);
            OP_SCALE: begin
                r_prod <= mul_p;
                r_neg  <= dev[DEV_W-1];
            end
            OP_OUT: begin
                r_sample <= sat;
                r_fs     <= i_cmd.from_stored;
            end
            default: ;
        endcase
    end

    assign o_sts.norm_done = r_m[31];
    assign o_sample        = r_sample;
    assign o_from_stored   = r_fs;

endmodule

// ===== rtl/gaussian_box_muller_generator_top.sv =====
// sequence: a fresh pair gives its sine sample after normalization, 32 log squaring steps,
// 28 square root steps and the sine/cosine series; the log, angle, series, deviate and scale
// steps share one 33x33 multiplier; a stored sample needs only the scale and output steps
// throughput: one item in flight, next input taken once the result is in the output register
// reset: synchronous active low, clears control, stored flag, output valid, mean 0, spread 1.0
module gaussian_box_muller_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gbm_in_if.sink      i_in,
    gbm_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gbm_pkg::*;

    logic [31:0] r_mean, r_spread;
    t_cmd        cmd;
    t_sts        sts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SPREAD) ? r_spread : r_mean;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean   <= 32'd0;
            r_spread <= 32'd65536;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_MEAN) begin
                r_mean <= pwdata;
            end else begin
                r_spread <= pwdata;
            end
        end
    end

    gbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    gbm_dp u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_uniform_radius (i_in.uniform_radius),
        .i_uniform_angle  (i_in.uniform_angle),
        .i_mean           (r_mean),
        .i_spread         (r_spread),
        .o_sample         (o_out.sample),
        .o_from_stored    (o_out.from_stored)
    );

endmodule

// ===== rtl/gbm_chk.sv =====
module gbm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_sample,
    input logic        i_from_stored,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);
    logic r_seen, r_last_fs;
    logic out_xfer, cfg_wr;

    assign out_xfer = i_out_valid && i_out_ready;
    assign cfg_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= 1'b0;
            r_last_fs <= 1'b0;
        end else if (out_xfer) begin
            r_seen    <= 1'b1;
            r_last_fs <= i_from_stored;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_sample) && $stable(i_from_stored)))
        else $error("result changed while stalled");

    // stored sample only right after a fresh one
    a_pairing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && i_from_stored) |-> (r_seen && !r_last_fs))
        else $error("stored sample out of order");

    // one item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while busy");

    // register readback follows a write
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> ((paddr[2] != $past(paddr[2])) || (prdata == $past(pwdata))))
        else $error("register readback mismatch");

endmodule

bind gaussian_box_muller_generator_top gbm_chk u_gbm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_sample      (o_out.sample),
    .i_from_stored (o_out.from_stored),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);
